// ===== src/ssmv_pkg.sv =====
// Shared constants, types and Q16.16 helper functions for the symmetric
// sparse matrix-vector multiply-add block.
// No dependencies.
package ssmv_pkg;

   // storage sizes
   localparam int MAX_ROWS    = 1024;
   localparam int MAX_ENTRIES = 4096;
   localparam int ROW_W       = $clog2(MAX_ROWS);
   localparam int ROW_CNT_W   = $clog2(MAX_ROWS + 1);
   localparam int ENT_W       = $clog2(MAX_ENTRIES);
   localparam int ENT_CNT_W   = $clog2(MAX_ENTRIES + 1);

   // fixed field widths
   localparam int OP_W   = 3;
   localparam int SLOT_W = 12;
   localparam int DATA_W = 32;
   localparam int CSR_W  = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_LOAD_ENTRY = 3'd0;
   localparam logic [OP_W-1:0] OP_LOAD_X     = 3'd1;
   localparam logic [OP_W-1:0] OP_LOAD_Y     = 3'd2;
   localparam logic [OP_W-1:0] OP_COMPUTE    = 3'd3;
   localparam logic [OP_W-1:0] OP_READ_Z     = 3'd4;

   // register indexes
   localparam logic [CSR_W-1:0] CSR_ALPHA   = 2'd0;
   localparam logic [CSR_W-1:0] CSR_BETA    = 2'd1;
   localparam logic [CSR_W-1:0] CSR_ROWS    = 2'd2;
   localparam logic [CSR_W-1:0] CSR_ENTRIES = 2'd3;

   // reset values
   localparam logic signed [DATA_W-1:0] ALPHA_RESET = 32'sd65536;
   localparam logic signed [DATA_W-1:0] BETA_RESET  = 32'sd0;

   localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

   // one stored upper-triangle entry
   typedef struct packed {
      logic [ROW_W-1:0]         row;
      logic [ROW_W-1:0]         col;
      logic signed [DATA_W-1:0] value;
   } entry_type;

   // sequencer states
   typedef enum logic [12:0] {
      S_IDLE     = 13'b0000000000001,
      S_ZREAD    = 13'b0000000000010,
      S_INIT_RD  = 13'b0000000000100,
      S_INIT_MUL = 13'b0000000001000,
      S_INIT_WR  = 13'b0000000010000,
      S_ENT_RD   = 13'b0000000100000,
      S_ENT_CHK  = 13'b0000001000000,
      S_ENT_T    = 13'b0000010000000,
      S_ENT_MUL1 = 13'b0000100000000,
      S_ENT_ACC1 = 13'b0001000000000,
      S_ENT_MUL2 = 13'b0010000000000,
      S_ENT_ACC2 = 13'b0100000000000,
      S_DONE     = 13'b1000000000000
   } state_type;

   // floor of a product by 2^16, saturated to 32 bits
   function automatic logic signed [DATA_W-1:0] q16_sat(input logic signed [63:0] p);
      logic signed [47:0] s;
      s = 48'(p >>> 16);
      if (s[47:31] == '0 || s[47:31] == '1) begin
         return s[31:0];
      end else if (s[47]) begin
         return Q_MIN;
      end else begin
         return Q_MAX;
      end
   endfunction

   // saturating 32-bit add
   function automatic logic signed [DATA_W-1:0] add_sat(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
      logic signed [DATA_W:0] s;
      s = 33'(a) + 33'(b);
      if (s[DATA_W] != s[DATA_W-1]) begin
         return s[DATA_W] ? Q_MIN : Q_MAX;
      end else begin
         return s[DATA_W-1:0];
      end
   endfunction

endpackage

// ===== src/symmetric_sparse_mat_vec_mult_add.sv =====
// Symmetric sparse matrix-vector multiply-add, z = beta*y + alpha*A*x.
// Depends on ssmv_pkg (constants, entry and state types, Q16.16 helpers).
//
// Load beats (entry, x, y) and unknown ops are answered from the idle state; a z
// read passes through S_ZREAD. A compute beat first runs a row pass over all
// 1024 z rows (y read, beta multiply, z write), then an entry pass in which an
// out-of-range entry is only read and checked, a diagonal entry also forms
// t = alpha*value and updates z[row], and an off-diagonal one also updates
// z[col]; a final state posts the result. The pace is set by the single shared
// 32x32 multiplier and the one read port of each vector memory, which every
// read-modify-write of z goes through in turn. The input is not ready while a
// compute or z read is in progress, nor while a response beat waits to be
// taken. Before the first compute, z reads as zero.
module symmetric_sparse_mat_vec_mult_add (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // slot_index[11:0], entry_row[21:12], entry_col[31:22],
                                    // data_value[63:32]
   input  logic [2:0]  req_tuser,   // op[2:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // read_value[31:0]
   output logic        rsp_tuser,   // status[0]
   // register write port
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   localparam int RW  = ssmv_pkg::ROW_W;
   localparam int RCW = ssmv_pkg::ROW_CNT_W;
   localparam int EW  = ssmv_pkg::ENT_W;
   localparam int ECW = ssmv_pkg::ENT_CNT_W;
   localparam int DW  = ssmv_pkg::DATA_W;

   // request fields
   logic [ssmv_pkg::OP_W-1:0]   req_op;
   logic [ssmv_pkg::SLOT_W-1:0] req_slot;
   logic [RW-1:0]               req_row;
   logic [RW-1:0]               req_col;
   logic signed [DW-1:0]        req_data;

   assign req_op   = req_tuser;
   assign req_slot = req_tdata[11:0];
   assign req_row  = req_tdata[21:12];
   assign req_col  = req_tdata[31:22];
   assign req_data = req_tdata[63:32];

   // configuration registers
   logic signed [DW-1:0] alpha_ff;
   logic signed [DW-1:0] beta_ff;
   logic [RCW-1:0]       rows_ff;
   logic [ECW-1:0]       entries_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff   <= ssmv_pkg::ALPHA_RESET;
         beta_ff    <= ssmv_pkg::BETA_RESET;
         rows_ff    <= RCW'(ssmv_pkg::MAX_ROWS);
         entries_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            ssmv_pkg::CSR_ALPHA:   alpha_ff   <= csr_wdata;
            ssmv_pkg::CSR_BETA:    beta_ff    <= csr_wdata;
            ssmv_pkg::CSR_ROWS:    rows_ff    <= csr_wdata[RCW-1:0];
            ssmv_pkg::CSR_ENTRIES: entries_ff <= csr_wdata[ECW-1:0];
            default: ;
         endcase
      end
   end

   // counts in use, clamped to the storage size
   logic [RCW-1:0] n_eff;
   logic [ECW-1:0] m_eff;

   assign n_eff = (rows_ff > RCW'(ssmv_pkg::MAX_ROWS)) ? RCW'(ssmv_pkg::MAX_ROWS) : rows_ff;
   assign m_eff = (entries_ff > ECW'(ssmv_pkg::MAX_ENTRIES)) ?
                  ECW'(ssmv_pkg::MAX_ENTRIES) : entries_ff;

   // control and datapath registers
   ssmv_pkg::state_type  state_ff, state_in;
   logic [RW-1:0]        i_ff, i_in;
   logic [ECW-1:0]       k_ff, k_in;
   logic [RW-1:0]        r_ff, r_in;
   logic [RW-1:0]        c_ff, c_in;
   logic signed [DW-1:0] t_ff, t_in;
   logic signed [63:0]   prod_ff;
   logic                 rd_bad_ff, rd_bad_in;
   logic                 z_valid_ff, z_valid_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0] rsp_value_ff;
   logic                 rsp_status_ff;
   logic                 load_out;
   logic signed [DW-1:0] out_value;
   logic                 out_status;
   logic                 out_free;

   // memory ports
   logic                  ent_we, ent_re;
   logic [EW-1:0]         ent_wa, ent_ra;
   ssmv_pkg::entry_type   ent_wd, ent_rd_ff;
   logic                  x_we, x_re, y_we, y_re, z_we, z_re;
   logic [RW-1:0]         x_ra, y_ra, z_ra, z_wa;
   logic signed [DW-1:0]  z_wd;
   logic signed [DW-1:0]  x_rd_ff, y_rd_ff, z_rd_ff;

   ssmv_pkg::entry_type  ent_mem [ssmv_pkg::MAX_ENTRIES];
   logic signed [DW-1:0] x_mem   [ssmv_pkg::MAX_ROWS];
   logic signed [DW-1:0] y_mem   [ssmv_pkg::MAX_ROWS];
   logic signed [DW-1:0] z_mem   [ssmv_pkg::MAX_ROWS];

   // shared multiplier
   logic signed [DW-1:0] mul_a, mul_b;
   logic signed [63:0]   mul_p;

   assign mul_a = (state_ff == ssmv_pkg::S_INIT_MUL) ? beta_ff :
                  (state_ff == ssmv_pkg::S_ENT_CHK)  ? alpha_ff : t_ff;
   assign mul_b = (state_ff == ssmv_pkg::S_INIT_MUL) ? y_rd_ff :
                  (state_ff == ssmv_pkg::S_ENT_CHK)  ? ent_rd_ff.value : x_rd_ff;
   assign mul_p = 64'(mul_a) * 64'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
   end

   // handshake
   logic accept;
   logic req_bad_entry;
   logic req_bad_index;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ssmv_pkg::S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;

   assign req_bad_index = {1'b0, req_slot} >= {2'b0, n_eff};
   assign req_bad_entry = ({1'b0, req_slot} >= m_eff) ||
                          ({1'b0, req_row} >= n_eff) || ({1'b0, req_col} >= n_eff);

   // lower entries are stored swapped
   always_comb begin
      if (req_col < req_row) begin
         ent_wd.row = req_col;
         ent_wd.col = req_row;
      end else begin
         ent_wd.row = req_row;
         ent_wd.col = req_col;
      end
      ent_wd.value = req_data;
   end

   assign ent_wa = req_slot[EW-1:0];

   // sequencer
   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      k_in       = k_ff;
      r_in       = r_ff;
      c_in       = c_ff;
      t_in       = t_ff;
      rd_bad_in  = rd_bad_ff;
      z_valid_in = z_valid_ff;
      load_out   = 1'b0;
      out_value  = '0;
      out_status = 1'b0;
      ent_we     = 1'b0;
      ent_re     = 1'b0;
      ent_ra     = k_ff[EW-1:0];
      x_we       = 1'b0;
      x_re       = 1'b0;
      x_ra       = c_ff;
      y_we       = 1'b0;
      y_re       = 1'b0;
      y_ra       = i_ff;
      z_we       = 1'b0;
      z_wa       = r_ff;
      z_wd       = '0;
      z_re       = 1'b0;
      z_ra       = r_ff;

      case (state_ff)
         ssmv_pkg::S_IDLE: begin
            if (accept) begin
               case (req_op)
                  ssmv_pkg::OP_LOAD_ENTRY: begin
                     ent_we     = !req_bad_entry;
                     load_out   = 1'b1;
                     out_status = req_bad_entry;
                  end
                  ssmv_pkg::OP_LOAD_X: begin
                     x_we       = !req_bad_index;
                     load_out   = 1'b1;
                     out_status = req_bad_index;
                  end
                  ssmv_pkg::OP_LOAD_Y: begin
                     y_we       = !req_bad_index;
                     load_out   = 1'b1;
                     out_status = req_bad_index;
                  end
                  ssmv_pkg::OP_COMPUTE: begin
                     i_in     = '0;
                     state_in = ssmv_pkg::S_INIT_RD;
                  end
                  ssmv_pkg::OP_READ_Z: begin
                     z_re      = 1'b1;
                     z_ra      = req_slot[RW-1:0];
                     rd_bad_in = req_bad_index;
                     state_in  = ssmv_pkg::S_ZREAD;
                  end
                  default: begin
                     load_out = 1'b1;
                  end
               endcase
            end
         end
         ssmv_pkg::S_ZREAD: begin
            if (out_free) begin
               load_out   = 1'b1;
               out_value  = (rd_bad_ff || !z_valid_ff) ? '0 : z_rd_ff;
               out_status = rd_bad_ff;
               state_in   = ssmv_pkg::S_IDLE;
            end
         end
         // row pass: z starts as beta*y inside the rows in use, zero elsewhere
         ssmv_pkg::S_INIT_RD: begin
            y_re     = 1'b1;
            state_in = ssmv_pkg::S_INIT_MUL;
         end
         ssmv_pkg::S_INIT_MUL: begin
            state_in = ssmv_pkg::S_INIT_WR;
         end
         ssmv_pkg::S_INIT_WR: begin
            z_we = 1'b1;
            z_wa = i_ff;
            z_wd = (beta_ff != '0 && {1'b0, i_ff} < n_eff) ? ssmv_pkg::q16_sat(prod_ff) : '0;
            if (i_ff == RW'(ssmv_pkg::MAX_ROWS - 1)) begin
               k_in     = '0;
               state_in = (m_eff == '0) ? ssmv_pkg::S_DONE : ssmv_pkg::S_ENT_RD;
            end else begin
               i_in     = i_ff + RW'(1);
               state_in = ssmv_pkg::S_INIT_RD;
            end
         end
         // entry pass
         ssmv_pkg::S_ENT_RD: begin
            ent_re   = 1'b1;
            state_in = ssmv_pkg::S_ENT_CHK;
         end
         ssmv_pkg::S_ENT_CHK: begin
            r_in = ent_rd_ff.row;
            c_in = ent_rd_ff.col;
            if ({1'b0, ent_rd_ff.row} >= n_eff || {1'b0, ent_rd_ff.col} >= n_eff) begin
               if (k_ff + ECW'(1) >= m_eff) begin
                  state_in = ssmv_pkg::S_DONE;
               end else begin
                  k_in     = k_ff + ECW'(1);
                  state_in = ssmv_pkg::S_ENT_RD;
               end
            end else begin
               x_re     = 1'b1;
               x_ra     = ent_rd_ff.col;
               state_in = ssmv_pkg::S_ENT_T;
            end
         end
         ssmv_pkg::S_ENT_T: begin
            t_in     = ssmv_pkg::q16_sat(prod_ff);
            state_in = ssmv_pkg::S_ENT_MUL1;
         end
         ssmv_pkg::S_ENT_MUL1: begin
            z_re     = 1'b1;
            z_ra     = r_ff;
            state_in = ssmv_pkg::S_ENT_ACC1;
         end
         ssmv_pkg::S_ENT_ACC1: begin
            z_we = 1'b1;
            z_wa = r_ff;
            z_wd = ssmv_pkg::add_sat(z_rd_ff, ssmv_pkg::q16_sat(prod_ff));
            if (r_ff != c_ff) begin
               x_re     = 1'b1;
               x_ra     = r_ff;
               state_in = ssmv_pkg::S_ENT_MUL2;
            end else if (k_ff + ECW'(1) >= m_eff) begin
               state_in = ssmv_pkg::S_DONE;
            end else begin
               k_in     = k_ff + ECW'(1);
               state_in = ssmv_pkg::S_ENT_RD;
            end
         end
         ssmv_pkg::S_ENT_MUL2: begin
            z_re     = 1'b1;
            z_ra     = c_ff;
            state_in = ssmv_pkg::S_ENT_ACC2;
         end
         ssmv_pkg::S_ENT_ACC2: begin
            z_we = 1'b1;
            z_wa = c_ff;
            z_wd = ssmv_pkg::add_sat(z_rd_ff, ssmv_pkg::q16_sat(prod_ff));
            if (k_ff + ECW'(1) >= m_eff) begin
               state_in = ssmv_pkg::S_DONE;
            end else begin
               k_in     = k_ff + ECW'(1);
               state_in = ssmv_pkg::S_ENT_RD;
            end
         end
         ssmv_pkg::S_DONE: begin
            if (out_free) begin
               load_out   = 1'b1;
               z_valid_in = 1'b1;
               state_in   = ssmv_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ssmv_pkg::S_IDLE;
         end
      endcase
   end

   // response register next value
   always_comb begin
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssmv_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         z_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         z_valid_ff   <= z_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      k_ff      <= k_in;
      r_ff      <= r_in;
      c_ff      <= c_in;
      t_ff      <= t_in;
      rd_bad_ff <= rd_bad_in;
      if (load_out) begin
         rsp_value_ff  <= out_value;
         rsp_status_ff <= out_status;
      end
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_wa] <= ent_wd;
      end
      if (ent_re) begin
         ent_rd_ff <= ent_mem[ent_ra];
      end
   end

   // x memory
   always_ff @(posedge clock) begin
      if (x_we) begin
         x_mem[req_slot[RW-1:0]] <= req_data;
      end
      if (x_re) begin
         x_rd_ff <= x_mem[x_ra];
      end
   end

   // y memory
   always_ff @(posedge clock) begin
      if (y_we) begin
         y_mem[req_slot[RW-1:0]] <= req_data;
      end
      if (y_re) begin
         y_rd_ff <= y_mem[y_ra];
      end
   end

   // z memory
   always_ff @(posedge clock) begin
      if (z_we) begin
         z_mem[z_wa] <= z_wd;
      end
      if (z_re) begin
         z_rd_ff <= z_mem[z_ra];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ===== tb/sv/symmetric_sparse_mat_vec_mult_add_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for symmetric_sparse_mat_vec_mult_add: queued request beats,
// a predictor of z = beta*y + alpha*A*x and a response checker.
// Depends on ssmv_pkg and the block itself.
module symmetric_sparse_mat_vec_mult_add_tb;

   localparam int OW    = ssmv_pkg::OP_W;
   localparam int SW    = ssmv_pkg::SLOT_W;
   localparam int RW    = ssmv_pkg::ROW_W;
   localparam int DW    = ssmv_pkg::DATA_W;
   localparam int RCW   = ssmv_pkg::ROW_CNT_W;
   localparam int ECW   = ssmv_pkg::ENT_CNT_W;
   localparam int NROWS = ssmv_pkg::MAX_ROWS;
   localparam int NENTS = ssmv_pkg::MAX_ENTRIES;

   // codes that the block treats as no-ops
   localparam logic [OW-1:0] OP_SPARE_5 = 3'd5;
   localparam logic [OW-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OW-1:0] OP_SPARE_7 = 3'd7;
   localparam int IDLE_MAX = 12;
   localparam int LONG_HOLD = 300;
   // rows and entries used by the random phases; x and y are filled this far
   localparam int SMALL_ROWS = 40;

   typedef struct {
      logic [OW-1:0]        op;
      logic [SW-1:0]        slot;
      logic [RW-1:0]        row;
      logic [RW-1:0]        col;
      logic signed [DW-1:0] data;
      int                   gap;
   } mv_beat_type;

   typedef struct {
      logic signed [DW-1:0] value;
      logic                 status;
   } mv_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // slot_index, entry_row, entry_col, data_value
   logic [2:0]  req_tuser = '0;   // op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // read_value
   logic        rsp_tuser;        // status
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = '0;
   logic [31:0] csr_wdata = '0;

   symmetric_sparse_mat_vec_mult_add dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor copy of the registers and stores
   logic signed [DW-1:0] cfg_alpha = ssmv_pkg::ALPHA_RESET;
   logic signed [DW-1:0] cfg_beta = ssmv_pkg::BETA_RESET;
   logic [RCW-1:0]       cfg_rows = RCW'(NROWS);
   logic [ECW-1:0]       cfg_ents = '0;
   logic [RW-1:0]        ent_row [NENTS];
   logic [RW-1:0]        ent_col [NENTS];
   logic signed [DW-1:0] ent_val [NENTS];
   bit                   slot_loaded [NENTS];
   logic signed [DW-1:0] x_mem [NROWS];
   logic signed [DW-1:0] y_mem [NROWS];
   logic signed [DW-1:0] z_mem [NROWS];

   mv_beat_type   pending_beats[$];
   mv_result_type due_results[$];
   mv_beat_type   cur_beat;
   bit            req_accepted = 1'b0;
   int            gap_count = 0;
   int            rsp_wait = 0;
   int            hold_left = 0;
   int            send_idle_max = 0;
   int            recv_idle_max = 0;
   int            fails = 0;
   int            n_beats = 0, n_computes = 0, n_reads = 0, n_rejected = 0, n_settings = 0;

   function automatic int rows_eff();
      return (cfg_rows > NROWS) ? NROWS : int'(cfg_rows);
   endfunction

   function automatic int ents_eff();
      return (cfg_ents > NENTS) ? NENTS : int'(cfg_ents);
   endfunction

   function automatic logic signed [DW-1:0] clip32(input longint v);
      if (v > longint'(ssmv_pkg::Q_MAX)) return ssmv_pkg::Q_MAX;
      if (v < longint'(ssmv_pkg::Q_MIN)) return ssmv_pkg::Q_MIN;
      return v[DW-1:0];
   endfunction

   // floor(a*b / 2^16), saturated
   function automatic logic signed [DW-1:0] q_product(input logic signed [DW-1:0] a,
                                                    input logic signed [DW-1:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return clip32(p >>> 16);
   endfunction

   function automatic logic signed [DW-1:0] q_sum(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
      return clip32(longint'(a) + longint'(b));
   endfunction

   // full compute pass: beta*y start, then each in-range stored entry once or twice
   task automatic form_z_vector();
      int n, m, r, c;
      logic signed [DW-1:0] t;
      n = rows_eff();
      m = ents_eff();
      for (int i = 0; i < NROWS; i++) z_mem[i] = '0;
      if (cfg_beta != 0)
         for (int i = 0; i < n; i++) z_mem[i] = q_product(cfg_beta, y_mem[i]);
      for (int k = 0; k < m; k++) begin
         r = ent_row[k];
         c = ent_col[k];
         if (r < n && c < n) begin
            t = q_product(cfg_alpha, ent_val[k]);
            z_mem[r] = q_sum(z_mem[r], q_product(t, x_mem[c]));
            if (r != c) z_mem[c] = q_sum(z_mem[c], q_product(t, x_mem[r]));
         end
      end
   endtask

   // expected response of one request beat, updating the stores
   task automatic apply_request(input mv_beat_type b, output mv_result_type res);
      int n;
      n = rows_eff();
      res.value = '0;
      res.status = 1'b0;
      case (b.op)
         ssmv_pkg::OP_LOAD_ENTRY: begin
            if (b.slot >= ents_eff() || b.row >= n || b.col >= n) begin
               res.status = 1'b1;
            end else begin
               // lower-triangle entries are kept as row <= col
               ent_row[b.slot] = (b.col < b.row) ? b.col : b.row;
               ent_col[b.slot] = (b.col < b.row) ? b.row : b.col;
               ent_val[b.slot] = b.data;
            end
         end
         ssmv_pkg::OP_LOAD_X, ssmv_pkg::OP_LOAD_Y: begin
            if (b.slot >= n) res.status = 1'b1;
            else if (b.op == ssmv_pkg::OP_LOAD_X) x_mem[b.slot] = b.data;
            else y_mem[b.slot] = b.data;
         end
         ssmv_pkg::OP_COMPUTE: begin
            form_z_vector();
            n_computes++;
         end
         ssmv_pkg::OP_READ_Z: begin
            n_reads++;
            if (b.slot >= n) res.status = 1'b1;
            else res.value = z_mem[b.slot];
         end
         default: ;
      endcase
      if (res.status) n_rejected++;
      n_beats++;
   endtask

   // request capture, prediction and response checking
   always @(posedge clock) begin
      mv_result_type want;
      mv_beat_type   taken;
      if (reset) begin
         req_accepted = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               $error("response beat with nothing expected: read_value %0d status %0b",
                      $signed(rsp_tdata), rsp_tuser);
               fails++;
            end else begin
               want = due_results.pop_front();
               if (rsp_tdata !== want.value) begin
                  $error("read_value mismatch: expected %0d, actual %0d",
                         want.value, $signed(rsp_tdata));
                  fails++;
               end
               if (rsp_tuser !== want.status) begin
                  $error("status mismatch: expected %0b, actual %0b", want.status, rsp_tuser);
                  fails++;
               end
            end
            rsp_wait = $urandom_range(0, recv_idle_max);
         end
         req_accepted = req_tvalid && req_tready;
         if (req_accepted) begin
            taken.op = req_tuser;
            taken.slot = req_tdata[11:0];
            taken.row = req_tdata[21:12];
            taken.col = req_tdata[31:22];
            taken.data = req_tdata[63:32];
            apply_request(taken, want);
            due_results.push_back(want);
         end
      end
   end

   // request driver: next beat after its drawn gap
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_count = 0;
      end else if (!req_tvalid || req_accepted) begin
         if (pending_beats.size() != 0 && gap_count >= pending_beats[0].gap) begin
            cur_beat = pending_beats.pop_front();
            req_tdata <= {cur_beat.data, cur_beat.col, cur_beat.row, cur_beat.slot};
            req_tuser <= cur_beat.op;
            req_tvalid <= 1'b1;
            gap_count = 0;
         end else begin
            req_tvalid <= 1'b0;
            if (pending_beats.size() != 0) gap_count++;
         end
      end
   end

   // response ready: long hold first, then per-beat stall
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (rsp_wait > 0) begin
         rsp_tready <= 1'b0;
         if (rsp_tvalid) rsp_wait--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic signed [DW-1:0] pick_q();
      case ($urandom_range(0, 7))
         0: return ssmv_pkg::Q_MAX;
         1: return ssmv_pkg::Q_MIN;
         2: return '0;
         3, 4: return $urandom;
         default: return int'($urandom_range(0, 262143)) - 131072;
      endcase
   endfunction

   function automatic logic signed [DW-1:0] pick_scale();
      case ($urandom_range(0, 7))
         0: return 32'sd65536;
         1: return '0;
         2: return ssmv_pkg::Q_MAX;
         3: return ssmv_pkg::Q_MIN;
         4: return $urandom;
         default: return int'($urandom_range(0, 524288)) - 262144;
      endcase
   endfunction

   task automatic queue_beat(input logic [OW-1:0] op, input int slot, input int row,
                             input int col, input logic signed [DW-1:0] data);
      mv_beat_type b;
      b.op = op;
      b.slot = slot[SW-1:0];
      b.row = row[RW-1:0];
      b.col = col[RW-1:0];
      b.data = data;
      b.gap = $urandom_range(0, send_idle_max);
      if (op == ssmv_pkg::OP_LOAD_ENTRY && slot < ents_eff() && row < rows_eff() &&
          col < rows_eff())
         slot_loaded[slot] = 1'b1;
      pending_beats.push_back(b);
   endtask

   // a compute only ever walks slots that hold a loaded entry
   task automatic queue_compute();
      int n;
      n = rows_eff();
      for (int k = 0; k < ents_eff(); k++)
         if (!slot_loaded[k])
            queue_beat(ssmv_pkg::OP_LOAD_ENTRY, k, $urandom_range(0, n - 1),
                       $urandom_range(0, n - 1), pick_q());
      queue_beat(ssmv_pkg::OP_COMPUTE, $urandom_range(0, 4095), $urandom_range(0, 1023),
                 $urandom_range(0, 1023), $urandom);
   endtask

   task automatic wait_idle();
      do begin
         @(posedge clock);
         #1;
      end while (pending_beats.size() != 0 || req_tvalid || due_results.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [ssmv_pkg::CSR_W-1:0] idx, input logic [31:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         ssmv_pkg::CSR_ALPHA:   cfg_alpha = v;
         ssmv_pkg::CSR_BETA:    cfg_beta = v;
         ssmv_pkg::CSR_ROWS:    cfg_rows = v[RCW-1:0];
         ssmv_pkg::CSR_ENTRIES: cfg_ents = v[ECW-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic signed [DW-1:0] alpha,
                             input logic signed [DW-1:0] beta, input int rows,
                             input int ents);
      wait_idle();
      write_reg(ssmv_pkg::CSR_ALPHA, alpha);
      write_reg(ssmv_pkg::CSR_BETA, beta);
      write_reg(ssmv_pkg::CSR_ROWS, rows);
      write_reg(ssmv_pkg::CSR_ENTRIES, ents);
      @(posedge clock);
      #1;
      n_settings++;
   endtask

   // mostly well-formed loads, computes and reads, some noise
   task automatic run_random_phase(input int count);
      int n, m, sel, spare;
      logic [OW-1:0] noise_op;
      n = rows_eff();
      m = ents_eff();
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 30) begin
            queue_beat(ssmv_pkg::OP_LOAD_ENTRY, (m > 0) ? $urandom_range(0, m - 1) : 0,
                       $urandom_range(0, n - 1), $urandom_range(0, n - 1), pick_q());
         end else if (sel < 45) begin
            queue_beat(ssmv_pkg::OP_LOAD_X, $urandom_range(0, n - 1), $urandom_range(0, 1023),
                       $urandom_range(0, 1023), pick_q());
         end else if (sel < 55) begin
            queue_beat(ssmv_pkg::OP_LOAD_Y, $urandom_range(0, n - 1), $urandom_range(0, 1023),
                       $urandom_range(0, 1023), pick_q());
         end else if (sel < 80) begin
            queue_beat(ssmv_pkg::OP_READ_Z, $urandom_range(0, n - 1), $urandom_range(0, 1023),
                       $urandom_range(0, 1023), $urandom);
         end else if (sel < 84) begin
            queue_compute();
         end else if (sel < 93) begin
            // noise over the whole field ranges, never a compute
            spare = $urandom_range(0, 5);
            case (spare)
               0: noise_op = ssmv_pkg::OP_LOAD_ENTRY;
               1: noise_op = ssmv_pkg::OP_LOAD_X;
               2: noise_op = ssmv_pkg::OP_LOAD_Y;
               3: noise_op = OP_SPARE_5;
               4: noise_op = OP_SPARE_6;
               default: noise_op = OP_SPARE_7;
            endcase
            queue_beat(noise_op, $urandom_range(0, 4095), $urandom_range(0, 1023),
                       $urandom_range(0, 1023), $urandom);
         end else begin
            queue_beat(ssmv_pkg::OP_READ_Z, $urandom_range(0, 4095), $urandom_range(0, 1023),
                       $urandom_range(0, 1023), $urandom);
         end
      end
      queue_compute();
      for (int i = 0; i < ((n < 6) ? n : 6); i++) queue_beat(ssmv_pkg::OP_READ_Z, i, 0, 0, '0);
      queue_beat(ssmv_pkg::OP_READ_Z, $urandom_range(0, n - 1), 0, 0, '0);
   endtask

   // stimulus sequence
   initial begin
      for (int i = 0; i < NROWS; i++) begin
         x_mem[i] = '0;
         y_mem[i] = '0;
         z_mem[i] = '0;
      end
      for (int k = 0; k < NENTS; k++) begin
         ent_row[k] = '0;
         ent_col[k] = '0;
         ent_val[k] = '0;
         slot_loaded[k] = 1'b0;
      end
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      #1;

      // reset settings: reads before any compute, bad indexes, spare ops
      send_idle_max = IDLE_MAX;
      recv_idle_max = IDLE_MAX;
      queue_beat(ssmv_pkg::OP_READ_Z, 0, 0, 0, '0);
      queue_beat(ssmv_pkg::OP_READ_Z, 1023, 1023, 1023, ssmv_pkg::Q_MAX);
      queue_beat(ssmv_pkg::OP_READ_Z, 1024, 0, 0, '0);
      queue_beat(OP_SPARE_5, 4095, 1023, 1023, ssmv_pkg::Q_MIN);
      queue_beat(OP_SPARE_6, 0, 0, 0, ssmv_pkg::Q_MAX);
      queue_beat(OP_SPARE_7, 2048, 512, 512, -1);
      queue_beat(ssmv_pkg::OP_LOAD_ENTRY, 0, 0, 0, 32'sd65536);
      queue_beat(ssmv_pkg::OP_LOAD_X, 4095, 0, 0, 32'sd1);
      queue_beat(ssmv_pkg::OP_LOAD_Y, 1024, 0, 0, 32'sd1);

      // fill the low x and y elements and the top x element back to back
      wait_idle();
      send_idle_max = 0;
      recv_idle_max = 0;
      for (int i = 0; i < SMALL_ROWS; i++) begin
         queue_beat(ssmv_pkg::OP_LOAD_X, i, $urandom_range(0, 1023), $urandom_range(0, 1023),
                    pick_q());
         queue_beat(ssmv_pkg::OP_LOAD_Y, i, $urandom_range(0, 1023), $urandom_range(0, 1023),
                    pick_q());
      end
      queue_beat(ssmv_pkg::OP_LOAD_X, NROWS - 1, 0, 0, pick_q());

      // counts above the storage size act as the largest: top slots, lower entry swapped
      set_config(ssmv_pkg::Q_MAX, ssmv_pkg::Q_MIN, 2047, 8191);
      send_idle_max = IDLE_MAX;
      recv_idle_max = IDLE_MAX;
      queue_beat(ssmv_pkg::OP_LOAD_ENTRY, 4095, 1023, 0, 32'sd65536);
      queue_beat(ssmv_pkg::OP_LOAD_ENTRY, 2048, 0, 1023, ssmv_pkg::Q_MIN);
      queue_beat(ssmv_pkg::OP_READ_Z, 1024, 0, 0, '0);
      queue_beat(ssmv_pkg::OP_READ_Z, 1023, 0, 0, '0);

      // diagonal, lower and corner entries, then bad slot and compute
      set_config(32'sd65536, 32'sd0, NROWS, 3);
      queue_beat(ssmv_pkg::OP_LOAD_ENTRY, 0, 5, 5, 32'sd131072);
      queue_beat(ssmv_pkg::OP_LOAD_ENTRY, 1, 7, 3, ssmv_pkg::Q_MIN);
      queue_beat(ssmv_pkg::OP_LOAD_ENTRY, 2, 1023, 1023, ssmv_pkg::Q_MAX);
      queue_beat(ssmv_pkg::OP_LOAD_ENTRY, 3, 0, 0, 32'sd1);
      queue_compute();
      queue_beat(ssmv_pkg::OP_READ_Z, 5, 0, 0, '0);
      queue_beat(ssmv_pkg::OP_READ_Z, 3, 0, 0, '0);
      queue_beat(ssmv_pkg::OP_READ_Z, 7, 0, 0, '0);
      queue_beat(ssmv_pkg::OP_READ_Z, 1023, 0, 0, '0);

      // one row: every entry stale, z cleared above row 0
      set_config(ssmv_pkg::Q_MIN, ssmv_pkg::Q_MAX, 1, 3);
      queue_compute();
      queue_beat(ssmv_pkg::OP_READ_Z, 0, 0, 0, '0);
      queue_beat(ssmv_pkg::OP_READ_Z, 1, 0, 0, '0);
      queue_beat(ssmv_pkg::OP_LOAD_ENTRY, 0, 1, 0, 32'sd65536);

      // random settings, small sizes
      for (int p = 0; p < 10; p++) begin
         set_config(pick_scale(), ($urandom_range(0, 1) != 0) ? pick_scale() : '0,
                    $urandom_range(1, SMALL_ROWS),
                    ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 40));
         send_idle_max = ($urandom_range(0, 1) != 0) ? IDLE_MAX : 0;
         recv_idle_max = ($urandom_range(0, 1) != 0) ? IDLE_MAX : 0;
         if (p == 2) begin
            // receiver holds off while beats keep coming
            hold_left = LONG_HOLD;
            send_idle_max = 0;
         end
         run_random_phase(20);
      end

      wait_idle();
      repeat (16) @(posedge clock);
      $display("covered %0d request beats: %0d computes, %0d z reads, %0d rejected",
               n_beats, n_computes, n_reads, n_rejected);
      $display("across %0d register settings, with a %0d-cycle response hold",
               n_settings, LONG_HOLD);
      if (fails == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // hang guard
   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/ssmv_pkg.sv
src/symmetric_sparse_mat_vec_mult_add.sv
tb/sv/symmetric_sparse_mat_vec_mult_add_tb.sv
